// File: design/ssd_pkg.sv
// Shared constants, types and the segment glyph table for the scan driver.
package ssd_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned QUOT_W  = 14;
	localparam int unsigned PROD_W  = 30;

	localparam logic [1:0] REG_VALUE = 2'd0;
	localparam logic [1:0] REG_POINT = 2'd1;
	localparam logic [1:0] REG_MODE  = 2'd2;

	localparam logic [1:0] MODE_DEC  = 2'd0;
	localparam logic [1:0] MODE_HEX  = 2'd1;
	localparam logic [1:0] MODE_DASH = 2'd2;

	localparam logic [VALUE_W-1:0] POINT_RESET     = 16'd4;
	localparam int unsigned        MULTI_POINT_BIT = 15;
	localparam logic [QUOT_W-1:0]  DEC_LIMIT       = 14'd9999;
	localparam logic [6:0]         DASH_PATTERN    = 7'h40;

	// reciprocal constants: floor(x * K >> S) equals x / D for x below 10000
	localparam logic [15:0] RECIP_1000 = 16'd8389;
	localparam int unsigned SHIFT_1000 = 23;
	localparam logic [15:0] RECIP_100  = 16'd5243;
	localparam int unsigned SHIFT_100  = 19;
	localparam logic [15:0] RECIP_10   = 16'd52429;
	localparam int unsigned SHIFT_10   = 19;

	typedef struct packed {
		logic [1:0]        pos;
		logic [QUOT_W-1:0] quot;
		logic              dec;
		logic              dash;
		logic              dp;
	} ssd_ctl_t;

	function automatic logic [6:0] glyph(input logic [3:0] d);
		logic [6:0] g;
		case (d)
			4'h0: g = 7'h3F;
			4'h1: g = 7'h06;
			4'h2: g = 7'h5B;
			4'h3: g = 7'h4F;
			4'h4: g = 7'h66;
			4'h5: g = 7'h6D;
			4'h6: g = 7'h7D;
			4'h7: g = 7'h07;
			4'h8: g = 7'h7F;
			4'h9: g = 7'h6F;
			4'hA: g = 7'h77;
			4'hB: g = 7'h7C;
			4'hC: g = 7'h39;
			4'hD: g = 7'h5E;
			4'hE: g = 7'h79;
			default: g = 7'h71;
		endcase
		return g;
	endfunction

endpackage

// File: design/ssd_digit_pick.sv
// Selects the source digit (decimal quotient or hex nibble) and point for one position.
module ssd_digit_pick (
	input  logic [ssd_pkg::VALUE_W-1:0] value,
	input  logic [ssd_pkg::VALUE_W-1:0] point,
	input  logic [1:0]                  mode,
	input  logic [1:0]                  pos,
	output ssd_pkg::ssd_ctl_t           ctl
);
	import ssd_pkg::*;

	logic [QUOT_W-1:0] vsat;
	logic [15:0]       recip;
	logic [PROD_W-1:0] prod;
	logic [QUOT_W-1:0] quot;
	logic [3:0]        nibble;
	logic              dp;
	logic              is_dec;
	logic              is_dash;

	always_comb begin
		vsat = (value > VALUE_W'(DEC_LIMIT)) ? DEC_LIMIT : value[QUOT_W-1:0];
		unique case (pos)
			2'd0: recip = RECIP_1000;
			2'd1: recip = RECIP_100;
			default: recip = RECIP_10;
		endcase
		prod = PROD_W'(vsat) * PROD_W'(recip);
		unique case (pos)
			2'd0: quot = QUOT_W'(prod >> SHIFT_1000);
			2'd1: quot = QUOT_W'(prod >> SHIFT_100);
			2'd2: quot = QUOT_W'(prod >> SHIFT_10);
			default: quot = vsat;
		endcase
		unique case (pos)
			2'd0: nibble = value[15:12];
			2'd1: nibble = value[11:8];
			2'd2: nibble = value[7:4];
			default: nibble = value[3:0];
		endcase
		if (point[MULTI_POINT_BIT]) begin
			dp = point[pos];
		end else begin
			dp = (point == VALUE_W'(pos));
		end
		is_dec  = (mode == MODE_DEC);
		is_dash = (mode == MODE_DASH);

		ctl.pos  = pos;
		ctl.quot = is_dec ? quot : QUOT_W'(nibble);
		ctl.dec  = is_dec;
		ctl.dash = is_dash;
		ctl.dp   = dp & ~is_dash;
	end

endmodule

// File: design/ssd_glyph_enc.sv
// In decimal mode reduces the quotient to one decimal digit; encodes the segment pattern or dash.
module ssd_glyph_enc (
	input  ssd_pkg::ssd_ctl_t ctl,
	output logic [6:0]        segments,
	output logic              decimal_point
);
	import ssd_pkg::*;

	logic [PROD_W-1:0] prod;
	logic [QUOT_W-1:0] tens;
	logic [QUOT_W-1:0] rem;
	logic [3:0]        digit;

	always_comb begin
		prod  = PROD_W'(ctl.quot) * PROD_W'(RECIP_10);
		tens  = QUOT_W'(prod >> SHIFT_10);
		rem   = ctl.quot - ((tens << 3) + (tens << 1));
		digit = ctl.dec ? rem[3:0] : ctl.quot[3:0];
		segments      = ctl.dash ? DASH_PATTERN : glyph(digit);
		decimal_point = ctl.dp;
	end

endmodule

// File: design/seven_segment_scan_driver_core.sv
// Top level of the four-digit seven-segment scan driver.
// Usage:
//   Input channel (in_valid/in_stall/tick): each accepted word advances the
//   scan position by one when tick is set, else keeps it; position 0 is the
//   leftmost digit and the first tick after reset selects position 1.
//   Output channel (out_valid/out_stall): one word per input word carrying
//   digit_index, segments (bit0 a .. bit6 g) and decimal_point.
//   Configuration: cfg_wr_en with cfg_index 0 value, 1 point select,
//   2 mode (0 decimal saturated at 9999, 1 or 3 hex, 2 dashes); index 3
//   is ignored. Write only while no word is in flight.
// Pipeline: the input register loads at the accept edge, then digit select
//   with one reciprocal multiply feeds the stage-two register, then glyph
//   encode with one more feeds the output register.
// Throughput: one word per cycle; each stage moves as soon as the next one
//   is empty or draining, so bubbles close up under output stall.
// Reset: arst_n clears the scan position to 0, value 0, point select 4,
//   decimal mode, and empties the pipeline.
// Stall: with out_stall high the output word holds; in_stall rises only
//   once all three stages hold words and out_stall is high.
module seven_segment_scan_driver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  digit_index,
	output logic [6:0]  segments,
	output logic        decimal_point,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [ssd_pkg::VALUE_W-1:0] cfg_data
);
	import ssd_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] point_q;
	logic [1:0]         mode_q;
	logic [1:0]         pos_q;
	logic [1:0]         pos_next;

	logic               valid_s1;
	logic [1:0]         pos_s1;
	logic               valid_s2;
	ssd_ctl_t           ctl_s2;
	ssd_ctl_t           ctl_pick;
	logic               out_valid_q;
	logic [1:0]         digit_index_q;
	logic [6:0]         segments_q;
	logic               decimal_point_q;
	logic [6:0]         seg_enc;
	logic               dp_enc;

	logic               ready_out;
	logic               ready_s2;
	logic               ready_s1;
	logic               in_accept;

	assign ready_out = ~out_valid_q | ~out_stall;
	assign ready_s2  = ~valid_s2 | ready_out;
	assign ready_s1  = ~valid_s1 | ready_s2;
	assign in_stall  = ~ready_s1;
	assign in_accept = in_valid & ready_s1;
	assign pos_next  = pos_q + {1'b0, tick};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			point_q <= POINT_RESET;
			mode_q  <= MODE_DEC;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_VALUE: value_q <= cfg_data;
				REG_POINT: point_q <= cfg_data;
				REG_MODE:  mode_q  <= cfg_data[1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				pos_q <= pos_next;
			end
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pos_s1 <= pos_next;
		end
		if (ready_s2 && valid_s1) begin
			ctl_s2 <= ctl_pick;
		end
		if (ready_out && valid_s2) begin
			digit_index_q   <= ctl_s2.pos;
			segments_q      <= seg_enc;
			decimal_point_q <= dp_enc;
		end
	end

	ssd_digit_pick u_pick (
		.value (value_q),
		.point (point_q),
		.mode  (mode_q),
		.pos   (pos_s1),
		.ctl   (ctl_pick)
	);

	ssd_glyph_enc u_enc (
		.ctl           (ctl_s2),
		.segments      (seg_enc),
		.decimal_point (dp_enc)
	);

	assign out_valid     = out_valid_q;
	assign digit_index   = digit_index_q;
	assign segments      = segments_q;
	assign decimal_point = decimal_point_q;

`ifndef SYNTHESIS
	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && tick |=> pos_q == $past(pos_q) + 2'd1)
		else $error("scan position did not advance on tick");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall) |=> pos_q == $past(pos_q))
		else $error("scan position moved without an accepted word");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_valid_q && out_stall)
		else $error("input stalled while pipeline has a bubble");

	a_s1_keep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(pos_s1))
		else $error("stage one word dropped under stall");
`endif

endmodule

// File: dv/scan_word_checker.sv
// Checker for the scan driver: predicts each digit word from the input side and compares outputs.
module scan_word_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        tick,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [1:0]                  digit_index,
	input  logic [6:0]                  segments,
	input  logic                        decimal_point,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [ssd_pkg::VALUE_W-1:0] cfg_data,
	output int                          failures,
	output int                          pending,
	output int                          checked
);
	import ssd_pkg::*;

	localparam logic [VALUE_W-1:0] DECIMAL_MAX  = 16'd9999;
	localparam logic [VALUE_W-1:0] POINT_AT_RST = 16'd4;

	// seven-segment font, digit 0 in the low bits
	localparam logic [16*7-1:0] FONT = {
		7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
		7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	typedef struct packed {
		logic [1:0] pos;
		logic [6:0] seg;
		logic       dp;
	} digit_word_t;

	digit_word_t        digits_due[$];
	digit_word_t        due;
	logic [VALUE_W-1:0] shown_value;
	logic [VALUE_W-1:0] point_sel;
	logic [1:0]         mode;
	logic [1:0]         scan_pos;
	int                 mismatches;

	assign failures = mismatches + pending;

	function automatic digit_word_t predict_digit(input logic [1:0] pos);
		digit_word_t        w;
		logic [VALUE_W-1:0] v;
		logic [3:0]         d;
		w.pos = pos;
		if (mode == MODE_DASH) begin
			w.seg = DASH_PATTERN;
			w.dp  = 1'b0;
		end else begin
			if (mode == MODE_DEC) begin
				v = (shown_value > DECIMAL_MAX) ? DECIMAL_MAX : shown_value;
				case (pos)
					2'd0: d = 4'(v / 1000);
					2'd1: d = 4'((v / 100) % 10);
					2'd2: d = 4'((v / 10) % 10);
					default: d = 4'(v % 10);
				endcase
			end else begin
				d = shown_value[12 - 4 * pos +: 4];
			end
			w.seg = FONT[d * 7 +: 7];
			if (point_sel[MULTI_POINT_BIT])
				w.dp = point_sel[pos];
			else
				w.dp = (point_sel == {14'd0, pos});
		end
		return w;
	endfunction

	task automatic check_field(input string field, input logic [6:0] want,
			input logic [6:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_value = '0;
			point_sel   = POINT_AT_RST;
			mode        = MODE_DEC;
			scan_pos    = 2'd0;
			digits_due.delete();
			mismatches  = 0;
			checked     = 0;
			pending     = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_VALUE: shown_value = cfg_data;
					REG_POINT: point_sel = cfg_data;
					REG_MODE:  mode = cfg_data[1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (digits_due.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual pos %0d seg %h dp %b",
						$time, digit_index, segments, decimal_point);
					mismatches++;
				end else begin
					due = digits_due.pop_front();
					checked++;
					check_field("digit_index", 7'(due.pos), 7'(digit_index));
					check_field("segments", due.seg, segments);
					check_field("decimal_point", 7'(due.dp), 7'(decimal_point));
				end
			end
			if (in_valid && !in_stall) begin
				if (tick)
					scan_pos = scan_pos + 2'd1;
				digits_due.push_back(predict_digit(scan_pos));
			end
			pending = digits_due.size();
		end
	end

endmodule

// File: dv/tb_seven_segment_scan_driver_core.sv
// Testbench top for the seven-segment scan driver: clock, reset, stimulus and verdict.
module tb_seven_segment_scan_driver_core;
	import ssd_pkg::*;

	localparam int         RANDOM_WORDS = 550;
	localparam int         CALM_WORDS   = 100;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam logic [1:0] REG_UNUSED   = 2'd3;
	localparam logic [1:0] MODE_HEX_ALT = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               tick;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         digit_index;
	logic [6:0]         segments;
	logic               decimal_point;
	logic               cfg_wr_en;
	logic [1:0]         cfg_index;
	logic [VALUE_W-1:0] cfg_data;

	int   failures;
	int   pending;
	int   checked;
	int   cycles;
	int   sent;
	int   held;
	int   settings;
	logic calm;

	seven_segment_scan_driver_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.tick          (tick),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.digit_index   (digit_index),
		.segments      (segments),
		.decimal_point (decimal_point),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	scan_word_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.tick          (tick),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.digit_index   (digit_index),
		.segments      (segments),
		.decimal_point (decimal_point),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.pending       (pending),
		.checked       (checked)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d words outstanding", $time, cycles, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// random output backpressure
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [VALUE_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic set_display(input logic [VALUE_W-1:0] v, input logic [VALUE_W-1:0] p,
			input logic [1:0] m);
		write_reg(REG_VALUE, v);
		write_reg(REG_POINT, p);
		write_reg(REG_MODE, {14'd0, m});
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	task automatic random_settings();
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] p;
		case ($urandom_range(0, 5))
			0: v = 16'd0;
			1: v = 16'd9999;
			2: v = 16'd10000;
			3: v = 16'hFFFF;
			default: v = 16'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: p = 16'($urandom_range(0, 3));
			1: p = 16'($urandom);
			default: p = {1'b1, 15'($urandom)};
		endcase
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_VALUE, v);
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_POINT, p);
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_MODE, 16'($urandom));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, 16'($urandom));
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	task automatic send_word(input logic t);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		tick     <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (!t)
			held++;
	endtask

	// drop valid and hold until every predicted word has come out
	task automatic finish_phase();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic directed_phase(input logic [VALUE_W-1:0] v, input logic [VALUE_W-1:0] p,
			input logic [1:0] m, input logic [3:0] ticks);
		set_display(v, p, m);
		for (int i = 3; i >= 0; i--)
			send_word(ticks[i]);
		finish_phase();
	endtask

	task automatic random_phase(input int words);
		for (int i = 0; i < words; i++)
			send_word($urandom_range(0, 9) != 0);
		finish_phase();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		tick      = 1'b0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_VALUE;
		cfg_data  = '0;
		cycles    = 0;
		sent      = 0;
		held      = 0;
		settings  = 1;
		calm      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: decimal zero, point select out of range
		send_word(1'b1);
		send_word(1'b1);
		send_word(1'b0);
		send_word(1'b1);
		finish_phase();
		directed_phase(16'hFFFF, 16'h800F, MODE_DEC, 4'b1111);
		directed_phase(16'hFFFF, 16'd3, MODE_HEX, 4'b1101);
		directed_phase(16'hA5C3, 16'hFFFF, MODE_HEX_ALT, 4'b1111);
		write_reg(REG_UNUSED, 16'hFFFF);
		directed_phase(16'd1234, 16'h8005, MODE_DASH, 4'b0111);
		directed_phase(16'd9999, 16'd0, MODE_DEC, 4'b1011);

		while (sent < RANDOM_WORDS - CALM_WORDS) begin
			random_settings();
			random_phase($urandom_range(10, 50));
		end
		calm = 1'b1;
		random_settings();
		random_phase(CALM_WORDS);

		repeat (8) @(negedge clk);
		$display("Scan run: %0d words sent (%0d without tick) over %0d register settings",
			sent, held, settings);
		$display("Covered decimal, hex and dash modes; %0d digit words checked", checked);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
